FILE: sv/cple_pkg.sv
// shared constants, types and codes for the packed card list engine
package cple_pkg;

    // list geometry
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // request codes
    localparam logic [2:0] ACT_INSERT    = 3'd0;
    localparam logic [2:0] ACT_DELETE    = 3'd1;
    localparam logic [2:0] ACT_SEARCH    = 3'd2;
    localparam logic [2:0] ACT_READ      = 3'd3;
    localparam logic [2:0] ACT_OVERWRITE = 3'd4;
    localparam logic [2:0] ACT_CLEAR     = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // one stored card
    typedef struct packed {
        logic [3:0] rank;
        logic [1:0] suit;
        logic [2:0] player;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

FILE: sv/cple_ctrl.sv
// controller state machine: request transfer, execute cycle, result strobe
module cple_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output cple_pkg::ctl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // next state and strobe
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("execute cycle not followed by result strobe");
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted request did not enter execute");
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(cmd.exec))
        else $error("result strobe without execute cycle");
`endif

endmodule

FILE: sv/cple_dp.sv
// datapath: request register, row of card cells, count and result registers
module cple_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  cple_pkg::ctl_cmd_t cmd,
    input  logic [2:0]         action,
    input  logic [3:0]         index,
    input  logic [3:0]         card_rank,
    input  logic [1:0]         card_suit,
    input  logic [2:0]         player_id,
    output logic               found,
    output logic [3:0]         out_rank,
    output logic [1:0]         out_suit,
    output logic [2:0]         out_player,
    output logic [4:0]         list_length,
    output logic [1:0]         status
);

    // latched request
    logic [2:0]       act_reg;
    cple_pkg::idx_t   idx_reg;
    cple_pkg::entry_t card_reg;

    // list storage
    cple_pkg::entry_t cell_reg  [cple_pkg::CAPACITY];
    cple_pkg::entry_t cell_next [cple_pkg::CAPACITY];
    cple_pkg::cnt_t   count_reg;
    cple_pkg::cnt_t   count_next;

    // results
    logic             found_reg;
    logic             found_next;
    cple_pkg::entry_t rd_reg;
    cple_pkg::entry_t rd_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    logic [cple_pkg::CAPACITY-1:0] hit;
    cple_pkg::cnt_t                idx_ext;
    logic                          full;
    logic                          in_range;
    logic                          do_insert;
    logic                          do_delete;
    logic                          do_write;

    assign idx_ext  = cple_pkg::cnt_t'(idx_reg);
    assign full     = (count_reg == cple_pkg::cnt_t'(cple_pkg::CAPACITY));
    assign in_range = (idx_ext < count_reg);

    // request decode and result fields
    always_comb
    begin
        count_next  = count_reg;
        found_next  = 1'b0;
        rd_next     = '0;
        status_next = cple_pkg::ST_DONE;
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        do_write    = 1'b0;
        case (act_reg)
            cple_pkg::ACT_INSERT:
            begin
                if (full)
                    status_next = cple_pkg::ST_FULL;
                else if (idx_ext > count_reg)
                    status_next = cple_pkg::ST_RANGE;
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            cple_pkg::ACT_DELETE:
            begin
                if (!in_range)
                    status_next = cple_pkg::ST_RANGE;
                else
                begin
                    do_delete  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            cple_pkg::ACT_SEARCH:
            begin
                found_next = |hit;
            end
            cple_pkg::ACT_READ:
            begin
                if (!in_range)
                    status_next = cple_pkg::ST_RANGE;
                else
                    rd_next = cell_reg[idx_reg];
            end
            cple_pkg::ACT_OVERWRITE:
            begin
                if (!in_range)
                    status_next = cple_pkg::ST_RANGE;
                else
                    do_write = 1'b1;
            end
            cple_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // per cell compare and shift
    for (genvar j = 0; j < cple_pkg::CAPACITY; j++)
    begin : g_cell
        localparam cple_pkg::idx_t POS = cple_pkg::idx_t'(j);
        cple_pkg::entry_t lower;
        cple_pkg::entry_t upper;

        if (j == 0)
        begin : g_first
            assign lower = cell_reg[0];
        end
        else
        begin : g_lower
            assign lower = cell_reg[j-1];
        end

        if (j == cple_pkg::CAPACITY - 1)
        begin : g_last
            assign upper = cell_reg[j];
        end
        else
        begin : g_upper
            assign upper = cell_reg[j+1];
        end

        assign hit[j] = (cple_pkg::cnt_t'(j) < count_reg)
                        && (cell_reg[j].rank == card_reg.rank)
                        && (cell_reg[j].suit == card_reg.suit);

        always_comb
        begin
            cell_next[j] = cell_reg[j];
            if (do_insert && POS > idx_reg)
                cell_next[j] = lower;
            else if ((do_insert || do_write) && POS == idx_reg)
                cell_next[j] = card_reg;
            else if (do_delete && POS >= idx_reg)
                cell_next[j] = upper;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= action;
            idx_reg       <= index;
            card_reg.rank <= card_rank;
            card_reg.suit <= card_suit;
            card_reg.player <= player_id;
        end
    end

    // cell row and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cell_reg   <= cell_next;
            found_reg  <= found_next;
            rd_reg     <= rd_next;
            status_reg <= status_next;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    assign found       = found_reg;
    assign out_rank    = rd_reg.rank;
    assign out_suit    = rd_reg.suit;
    assign out_player  = rd_reg.player;
    assign list_length = count_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cple_pkg::cnt_t'(cple_pkg::CAPACITY))
        else $error("entry count beyond capacity");
    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && status_next != cple_pkg::ST_DONE |=> $stable(count_reg))
        else $error("refused request changed the count");
    a_idle_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg))
        else $error("count changed outside execute cycle");
`endif

endmodule

FILE: sv/packed_card_list_engine.sv
// top level of the packed card list engine: controller plus datapath
// sequence: a request taken at one edge executes in the next cycle; done is high
//   in the cycle after the execute cycle, for exactly one cycle
// requests: a new request is taken only in the idle state, not during the execute
//   cycle of the controller; shifts and compares cover all cells at once
// reset: rst_n clears the controller and the entry count; cell contents stay
//   undefined until written; results cannot be stalled by the receiver
module packed_card_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic [2:0] action,
    input  logic [3:0] index,
    input  logic [3:0] card_rank,
    input  logic [1:0] card_suit,
    input  logic [2:0] player_id,
    output logic       found,
    output logic [3:0] out_rank,
    output logic [1:0] out_suit,
    output logic [2:0] out_player,
    output logic [4:0] list_length,
    output logic [1:0] status
);

    cple_pkg::ctl_cmd_t cmd;

    // sequencing
    cple_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // list storage and result fields
    cple_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .index       (index),
        .card_rank   (card_rank),
        .card_suit   (card_suit),
        .player_id   (player_id),
        .found       (found),
        .out_rank    (out_rank),
        .out_suit    (out_suit),
        .out_player  (out_player),
        .list_length (list_length),
        .status      (status)
    );

endmodule

FILE: dv/packed_card_list_engine_tb.sv
// self-checking testbench for the packed card list engine
module packed_card_list_engine_tb;

    // codes outside the defined request set
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef enum int unsigned {MODE_GROW, MODE_SHRINK, MODE_MIX, MODE_NOISE} stim_mode_t;

    // one predicted result
    typedef struct packed {
        logic             found;
        cple_pkg::entry_t card;
        cple_pkg::cnt_t   length;
        logic [1:0]       status;
    } list_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    logic [2:0] action;
    logic [3:0] index;
    logic [3:0] card_rank;
    logic [1:0] card_suit;
    logic [2:0] player_id;
    logic       found;
    logic [3:0] out_rank;
    logic [1:0] out_suit;
    logic [2:0] out_player;
    logic [4:0] list_length;
    logic [1:0] status;

    // predictor state: shadow copy of the list
    cple_pkg::entry_t model_cards [cple_pkg::CAPACITY];
    cple_pkg::cnt_t   model_count;
    list_result_t     pending_results [$];
    list_result_t     oldest_result;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        gaps_on = 1'b1;
    int unsigned burst_left = 20;

    packed_card_list_engine u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .action     (action),
        .index      (index),
        .card_rank  (card_rank),
        .card_suit  (card_suit),
        .player_id  (player_id),
        .found      (found),
        .out_rank   (out_rank),
        .out_suit   (out_suit),
        .out_player (out_player),
        .list_length(list_length),
        .status     (status)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic cple_pkg::entry_t make_card(input logic [3:0] rank,
                                                   input logic [1:0] suit,
                                                   input logic [2:0] player);
        cple_pkg::entry_t card;
        card.rank   = rank;
        card.suit   = suit;
        card.player = player;
        return card;
    endfunction

    // random card with every field in range
    function automatic cple_pkg::entry_t random_card();
        return make_card(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                         3'($urandom_range(0, 7)));
    endfunction

    // apply one request to the shadow list and return the result it yields
    function automatic list_result_t apply_card_request(input logic [2:0] act,
                                                        input cple_pkg::idx_t idx,
                                                        input cple_pkg::entry_t card);
        list_result_t res;
        res = '0;
        case (act)
            cple_pkg::ACT_INSERT:
            begin
                if (model_count >= cple_pkg::CAPACITY)
                    res.status = cple_pkg::ST_FULL;
                else if (idx > model_count)
                    res.status = cple_pkg::ST_RANGE;
                else
                begin
                    // open a hole at idx by moving later entries up
                    for (int j = int'(model_count); j > int'(idx); j--)
                        model_cards[j] = model_cards[j-1];
                    model_cards[idx] = card;
                    model_count = model_count + 1'b1;
                end
            end
            cple_pkg::ACT_DELETE:
            begin
                if (idx >= model_count)
                    res.status = cple_pkg::ST_RANGE;
                else
                begin
                    // close the gap, only within the current length
                    for (int j = int'(idx); j + 1 < int'(model_count); j++)
                        model_cards[j] = model_cards[j+1];
                    model_count = model_count - 1'b1;
                end
            end
            cple_pkg::ACT_SEARCH:
            begin
                for (int j = 0; j < int'(model_count); j++)
                    if (model_cards[j].rank == card.rank && model_cards[j].suit == card.suit)
                        res.found = 1'b1;
            end
            cple_pkg::ACT_READ:
            begin
                if (idx >= model_count)
                    res.status = cple_pkg::ST_RANGE;
                else
                    res.card = model_cards[idx];
            end
            cple_pkg::ACT_OVERWRITE:
            begin
                if (idx >= model_count)
                    res.status = cple_pkg::ST_RANGE;
                else
                    model_cards[idx] = card;
            end
            cple_pkg::ACT_CLEAR:
                model_count = '0;
            default:
                ;
        endcase
        res.length = model_count;
        return res;
    endfunction

    // idle length before the next request: bursts with and without gaps
    function automatic int unsigned next_gap();
        int unsigned roll;
        if (burst_left == 0)
        begin
            gaps_on    = !gaps_on;
            burst_left = $urandom_range(5, 60);
        end
        burst_left = burst_left - 1;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // one request transfer; called and returns at a falling edge with start still high
    task automatic send_item(input logic [2:0] act, input cple_pkg::idx_t idx,
                             input cple_pkg::entry_t card);
        int unsigned gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action    <= act;
        index     <= idx;
        card_rank <= card.rank;
        card_suit <= card.suit;
        player_id <= card.player;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_card_request(act, idx, card));
        @(negedge clk);
    endtask

    task automatic check_field(input string field_name, input logic [4:0] expected,
                               input logic [4:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, expected, actual);
            error_count = error_count + 1;
        end
    endtask

    // result checker: every done pulse is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, length %0d status %0d",
                         $time, list_length, status);
                error_count = error_count + 1;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("found", 5'(oldest_result.found), 5'(found));
                check_field("out_rank", 5'(oldest_result.card.rank), 5'(out_rank));
                check_field("out_suit", 5'(oldest_result.card.suit), 5'(out_suit));
                check_field("out_player", 5'(oldest_result.card.player), 5'(out_player));
                check_field("list_length", 5'(oldest_result.length), list_length);
                check_field("status", 5'(oldest_result.status), 5'(status));
            end
        end
    end

    // index mostly inside span valid positions, sometimes anywhere
    function automatic cple_pkg::idx_t pick_index(input int unsigned span);
        int unsigned limit;
        limit = (span > cple_pkg::CAPACITY) ? cple_pkg::CAPACITY : span;
        if (limit == 0 || $urandom_range(0, 9) == 0)
            return cple_pkg::idx_t'($urandom_range(0, 15));
        return cple_pkg::idx_t'($urandom_range(0, limit - 1));
    endfunction

    task automatic send_random_request(input stim_mode_t mode);
        logic [2:0]       act;
        cple_pkg::idx_t   idx;
        cple_pkg::entry_t card;
        int unsigned      roll;
        int unsigned      pick;
        card = random_card();
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                act = (roll < 70) ? cple_pkg::ACT_INSERT : (roll < 80) ? cple_pkg::ACT_READ :
                      (roll < 90) ? cple_pkg::ACT_SEARCH : cple_pkg::ACT_OVERWRITE;
            MODE_SHRINK:
                act = (roll < 70) ? cple_pkg::ACT_DELETE : (roll < 80) ? cple_pkg::ACT_READ :
                      (roll < 90) ? cple_pkg::ACT_SEARCH : cple_pkg::ACT_OVERWRITE;
            MODE_MIX:
            begin
                if (roll < 3)
                    act = cple_pkg::ACT_CLEAR;
                else if (roll < 5)
                    act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_A : ACT_SPARE_B;
                else
                begin
                    case ($urandom_range(0, 4))
                        0: act = cple_pkg::ACT_INSERT;
                        1: act = cple_pkg::ACT_DELETE;
                        2: act = cple_pkg::ACT_SEARCH;
                        3: act = cple_pkg::ACT_READ;
                        default: act = cple_pkg::ACT_OVERWRITE;
                    endcase
                end
            end
            default:
                act = 3'($urandom_range(0, 7));
        endcase
        if (mode == MODE_NOISE)
            idx = cple_pkg::idx_t'($urandom_range(0, 15));
        else if (act == cple_pkg::ACT_INSERT)
            idx = pick_index(model_count + 1);
        else
            idx = pick_index(model_count);
        // half the searches look for a card that is in the list
        if (act == cple_pkg::ACT_SEARCH && model_count != 0 && $urandom_range(0, 1) == 1)
        begin
            pick      = $urandom_range(0, model_count - 1);
            card.rank = model_cards[pick].rank;
            card.suit = model_cards[pick].suit;
        end
        send_item(act, idx, card);
    endtask

    // refusals and misses on an empty list
    task automatic test_empty_list();
        send_item(cple_pkg::ACT_READ, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_DELETE, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_OVERWRITE, 4'd0, make_card(4'd15, 2'd3, 3'd7));
        send_item(cple_pkg::ACT_SEARCH, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_INSERT, 4'd1, make_card(4'd1, 2'd1, 3'd1));
        send_item(cple_pkg::ACT_INSERT, 4'd15, make_card(4'd15, 2'd3, 3'd7));
    endtask

    // insert and delete at the first and last positions, search of the last entry
    task automatic test_list_ends();
        send_item(cple_pkg::ACT_INSERT, 4'd0, make_card(4'd15, 2'd3, 3'd7));
        send_item(cple_pkg::ACT_INSERT, 4'd1, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_INSERT, 4'd0, make_card(4'd5, 2'd2, 3'd3));
        send_item(cple_pkg::ACT_INSERT, 4'd3, make_card(4'd9, 2'd1, 3'd4));
        send_item(cple_pkg::ACT_SEARCH, 4'd0, make_card(4'd9, 2'd1, 3'd0));
        send_item(cple_pkg::ACT_SEARCH, 4'd0, make_card(4'd9, 2'd2, 3'd4));
        send_item(cple_pkg::ACT_READ, 4'd3, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_READ, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_READ, 4'd4, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_OVERWRITE, 4'd3, make_card(4'd12, 2'd3, 3'd6));
        send_item(cple_pkg::ACT_OVERWRITE, 4'd4, make_card(4'd1, 2'd1, 3'd1));
        send_item(cple_pkg::ACT_DELETE, 4'd3, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_DELETE, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_DELETE, 4'd2, make_card(4'd0, 2'd0, 3'd0));
    endtask

    // spare codes leave the list alone; clear hides the stale cells
    task automatic test_spare_codes_and_clear();
        send_item(ACT_SPARE_A, 4'd15, make_card(4'd15, 2'd3, 3'd7));
        send_item(ACT_SPARE_B, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_CLEAR, 4'd0, make_card(4'd0, 2'd0, 3'd0));
        send_item(cple_pkg::ACT_SEARCH, 4'd0, make_card(4'd15, 2'd3, 3'd0));
    endtask

    // fill to capacity, push against the full list, then drain to empty
    task automatic test_fill_and_drain();
        repeat (10)
        begin
            send_item(cple_pkg::ACT_CLEAR, cple_pkg::idx_t'($urandom_range(0, 15)),
                      random_card());
            while (model_count < cple_pkg::CAPACITY)
                send_random_request(MODE_GROW);
            repeat (10) send_random_request(MODE_GROW);
            while (model_count > 0)
                send_random_request(MODE_SHRINK);
            repeat (3) send_random_request(MODE_SHRINK);
        end
    endtask

    // phases of one leaning with some noise mixed in
    task automatic test_random_mix();
        stim_mode_t mode;
        repeat (14)
        begin
            mode = stim_mode_t'($urandom_range(0, 2));
            repeat (50)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_random_request(MODE_NOISE);
                else
                    send_random_request(mode);
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = cple_pkg::ACT_SEARCH;
        index       = '0;
        card_rank   = '0;
        card_suit   = '0;
        player_id   = '0;
        model_count = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_list_ends();
        test_spare_codes_and_clear();
        test_fill_and_drain();
        test_random_mix();

        // drain outstanding results, then watch for stray strobes
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
sv/cple_pkg.sv
sv/cple_ctrl.sv
sv/cple_dp.sv
sv/packed_card_list_engine.sv
dv/packed_card_list_engine_tb.sv
